// ----- design/assert_macros.svh -----
// Shared assertion shorthands for the smoothing block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define CTWA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Condition that must never be seen outside reset.
`define CTWA_NEVER(label, clk, rst, cond) \
   `CTWA_ASSERT(label, clk, rst, !(cond))

`endif

// ----- design/ctwa_pkg.sv -----
package ctwa_pkg;

   localparam int TIME_W       = 32;
   localparam int POWER_W      = 16;
   localparam int SUM_W        = 24;
   localparam int CNT_W        = 7;
   localparam int WINDOW_W     = 12;
   localparam int HALF_W       = 22;
   localparam int HALF_STEP_MS = 500;

   localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(30 * HALF_STEP_MS);

   typedef struct packed {
      logic [TIME_W-1:0]  time_ms;
      logic [POWER_W-1:0] power_q4;
      logic               has_power;
      logic               end_of_ride;
   } in_type;

   typedef struct packed {
      logic [TIME_W-1:0]  sample_time_ms;
      logic [POWER_W-1:0] smoothed_q4;
      logic               has_value;
      logic               window_overflow;
      logic               last_of_run;
   } out_type;

   // Classified beat handed from the front to the engine.
   typedef struct packed {
      logic [TIME_W-1:0]  time_ms;
      logic [POWER_W-1:0] power_q4;
      logic               valid;
      logic               eor;
   } cls_type;

   // One ring entry.
   typedef struct packed {
      logic [TIME_W-1:0]  time_ms;
      logic [POWER_W-1:0] power_q4;
      logic               valid;
      logic [SUM_W-1:0]   sum_prefix;
      logic [CNT_W-1:0]   cnt_prefix;
   } ent_type;

endpackage

// ----- design/centered_time_window_average_unit.sv -----
// The engine takes one item at a time; each result costs time for every ring entry dropped
// or scanned at the window edges and for the serial divide, which with the single ring read
// port sets the per-result cost. A two-beat front queue keeps accepting.
// Reset: synchronous, active high; ring empty, window 30 s, ring contents undefined.
module centered_time_window_average_unit #(
   parameter int DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ctwa_pkg::in_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ctwa_pkg::out_type             rsp_data,
   input  logic                          csr_wen,
   input  logic [ctwa_pkg::WINDOW_W-1:0] csr_wdata
);
   import ctwa_pkg::*;

   // Front: classify each request beat and queue it.
   logic    q_valid;
   cls_type q_data;
   logic    q_pop;

   ctwa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop)
   );

   // Back: ring, window edges, divide, and the registered response beat.
   ctwa_engine #(
      .DEPTH (DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- design/ctwa_ram.sv -----
module ctwa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/ctwa_front.sv -----
module ctwa_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ctwa_pkg::in_type  req_data,
   output logic              q_valid,
   output ctwa_pkg::cls_type q_data,
   input  logic              q_pop
);
   import ctwa_pkg::*;

   localparam logic [1:0] QDEPTH = 2'd2;

   cls_type    q_ff [2];
   cls_type    cls;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   // Classify: a sample counts only when it has a reading and that reading is nonzero.
   always_comb begin
      cls.time_ms  = req_data.time_ms;
      cls.power_q4 = req_data.power_q4;
      cls.valid    = req_data.has_power && (req_data.power_q4 != '0);
      cls.eor      = req_data.end_of_ride;
   end

   assign req_ready = (cnt_ff != QDEPTH);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ----- design/ctwa_div.sv -----
module ctwa_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ctwa_pkg::SUM_W-1:0]    dividend,
   input  logic [ctwa_pkg::CNT_W-1:0]    divisor,
   output logic                          done,
   output logic [ctwa_pkg::SUM_W-1:0]    quotient
);
   import ctwa_pkg::*;

   localparam int STEP_W = $clog2(SUM_W);

   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    trial;

   // Restoring division, one quotient bit a cycle.
   always_comb begin
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- design/ctwa_engine.sv -----
`include "assert_macros.svh"

module ctwa_engine #(
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [ctwa_pkg::WINDOW_W-1:0]     csr_wdata,
   input  logic                              q_valid,
   input  ctwa_pkg::cls_type                 q_data,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ctwa_pkg::out_type                 rsp_data
);
   import ctwa_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 1;
   localparam int EW = $bits(ent_type);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_CHK     = 4'd1;
   localparam logic [3:0] S_CHK_EV  = 4'd2;
   localparam logic [3:0] S_L_RD    = 4'd3;
   localparam logic [3:0] S_L_EV    = 4'd4;
   localparam logic [3:0] S_R_RD    = 4'd5;
   localparam logic [3:0] S_R_EV    = 4'd6;
   localparam logic [3:0] S_SUM     = 4'd7;
   localparam logic [3:0] S_DIV     = 4'd8;
   localparam logic [3:0] S_EMIT    = 4'd9;
   localparam logic [3:0] S_APPEND  = 4'd10;
   localparam logic [3:0] S_FL      = 4'd11;
   localparam logic [3:0] S_FL_TGT  = 4'd12;
   localparam logic [3:0] S_PASS    = 4'd13;
   localparam logic [3:0] S_PASS_EV = 4'd14;
   localparam logic [3:0] S_DONE    = 4'd15;

   localparam logic [1:0] M_STEP  = 2'd0;
   localparam logic [1:0] M_FLUSH = 2'd1;
   localparam logic [1:0] M_PASS  = 2'd2;

   function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
      logic [SW-1:0] s;
      s = SW'(base) + SW'(off);
      if (s >= SW'(DEPTH)) begin
         s = s - SW'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   logic [3:0]        state_ff, state_in;
   logic [1:0]        mode_ff, mode_in;
   logic [CW-1:0]     occ_ff, occ_in;
   logic [CW-1:0]     pend_ff, pend_in;
   logic [AW-1:0]     oldest_ff, oldest_in;
   logic [SUM_W-1:0]  rsum_ff, rsum_in;
   logic [CNT_W-1:0]  rcnt_ff, rcnt_in;
   logic              ovf_ff, ovf_in;
   logic [HALF_W-1:0] half_ff, half_in;
   logic              stage_v_ff, stage_v_in;
   logic              rsp_valid_ff, rsp_valid_in;
   out_type           stage_ff, stage_in;
   out_type           rec_ff, rec_in;
   out_type           rsp_ff, rsp_in;
   cls_type           item_ff, item_in;
   ent_type           tgt_ff, tgt_in;
   logic [SUM_W-1:0]  base_sum_ff, base_sum_in;
   logic [CNT_W-1:0]  base_cnt_ff, base_cnt_in;
   logic [CW-1:0]     r_ff, r_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   ent_type           ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [EW-1:0]     ram_rdata;
   ent_type           rd_w;

   logic              div_start;
   logic              div_done;
   logic [SUM_W-1:0]  div_quo;

   logic              can_push;
   logic [CW-1:0]     f_off;
   logic [CW-1:0]     r_next;
   logic [TIME_W:0]   rd_plus;
   logic [TIME_W:0]   tgt_plus;
   logic              full;

   ctwa_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ctwa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rd_w     = ent_type'(ram_rdata);
   assign can_push = !rsp_valid_ff || rsp_ready;
   assign f_off    = occ_ff - pend_ff;
   assign r_next   = r_ff + 1'b1;
   assign rd_plus  = {1'b0, rd_w.time_ms} + (TIME_W + 1)'(half_ff);
   assign tgt_plus = {1'b0, tgt_ff.time_ms} + (TIME_W + 1)'(half_ff);
   assign full     = (occ_ff == CW'(DEPTH));

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      occ_in       = occ_ff;
      pend_in      = pend_ff;
      oldest_in    = oldest_ff;
      rsum_in      = rsum_ff;
      rcnt_in      = rcnt_ff;
      ovf_in       = ovf_ff;
      half_in      = half_ff;
      stage_v_in   = stage_v_ff;
      stage_in     = stage_ff;
      rec_in       = rec_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      item_in      = item_ff;
      tgt_in       = tgt_ff;
      base_sum_in  = base_sum_ff;
      base_cnt_in  = base_cnt_ff;
      r_in         = r_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = ring_at(oldest_ff, occ_ff);
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = ring_at(oldest_ff, f_off);
      div_start    = 1'b0;

      if (csr_wen) begin
         half_in = HALF_W'(csr_wdata) * HALF_W'(HALF_STEP_MS);
      end

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_data;
               mode_in = M_STEP;
               state_in = (half_ff != '0) ? S_CHK : S_APPEND;
            end
         end
         // Finalize pending samples whose window the new time has closed.
         S_CHK: begin
            if (pend_ff == '0) begin
               state_in = S_APPEND;
            end else begin
               ram_re   = 1'b1;
               state_in = S_CHK_EV;
            end
         end
         S_CHK_EV: begin
            if (rd_plus < {1'b0, item_ff.time_ms}) begin
               tgt_in   = rd_w;
               state_in = S_L_RD;
            end else begin
               state_in = S_APPEND;
            end
         end
         // Drop entries that fell out of the left edge.
         S_L_RD: begin
            if (f_off == '0) begin
               base_sum_in = tgt_ff.sum_prefix;
               base_cnt_in = tgt_ff.cnt_prefix;
               r_in        = f_off;
               state_in    = S_R_RD;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = oldest_ff;
               state_in  = S_L_EV;
            end
         end
         S_L_EV: begin
            if (rd_plus < {1'b0, tgt_ff.time_ms}) begin
               oldest_in = ring_at(oldest_ff, CW'(1));
               occ_in    = occ_ff - 1'b1;
               state_in  = S_L_RD;
            end else begin
               base_sum_in = rd_w.sum_prefix;
               base_cnt_in = rd_w.cnt_prefix;
               r_in        = f_off;
               state_in    = S_R_RD;
            end
         end
         // Advance the right edge while times stay inside the window.
         S_R_RD: begin
            if (r_next < occ_ff) begin
               ram_re    = 1'b1;
               ram_raddr = ring_at(oldest_ff, r_next);
               state_in  = S_R_EV;
            end else begin
               sum_in   = rsum_ff - base_sum_ff;
               cnt_in   = rcnt_ff - base_cnt_ff;
               state_in = S_SUM;
            end
         end
         S_R_EV: begin
            if ({1'b0, rd_w.time_ms} <= tgt_plus) begin
               r_in     = r_next;
               state_in = S_R_RD;
            end else begin
               sum_in   = rd_w.sum_prefix - base_sum_ff;
               cnt_in   = rd_w.cnt_prefix - base_cnt_ff;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (tgt_ff.valid && (cnt_ff != '0)) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               rec_in.sample_time_ms  = tgt_ff.time_ms;
               rec_in.smoothed_q4     = '0;
               rec_in.has_value       = 1'b0;
               rec_in.window_overflow = ovf_ff;
               rec_in.last_of_run     = 1'b0;
               pend_in  = pend_ff - 1'b1;
               state_in = S_EMIT;
            end
         end
         S_DIV: begin
            if (div_done) begin
               rec_in.sample_time_ms  = tgt_ff.time_ms;
               rec_in.smoothed_q4     = div_quo[POWER_W-1:0];
               rec_in.has_value       = 1'b1;
               rec_in.window_overflow = ovf_ff;
               rec_in.last_of_run     = 1'b0;
               pend_in  = pend_ff - 1'b1;
               state_in = S_EMIT;
            end
         end
         // Hold one result back so the last one of the item can be marked.
         S_EMIT: begin
            if (!stage_v_ff || can_push) begin
               if (stage_v_ff) begin
                  rsp_in       = stage_ff;
                  rsp_valid_in = 1'b1;
               end
               stage_in   = rec_ff;
               stage_v_in = 1'b1;
               case (mode_ff)
                  M_STEP:  state_in = S_CHK;
                  M_FLUSH: state_in = S_FL;
                  M_PASS:  state_in = S_PASS;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_APPEND: begin
            ram_we               = 1'b1;
            ram_wdata.time_ms    = item_ff.time_ms;
            ram_wdata.power_q4   = item_ff.power_q4;
            ram_wdata.valid      = item_ff.valid;
            ram_wdata.sum_prefix = rsum_ff;
            ram_wdata.cnt_prefix = rcnt_ff;
            if (item_ff.valid) begin
               rsum_in = rsum_ff + SUM_W'(item_ff.power_q4);
               rcnt_in = rcnt_ff + 1'b1;
            end
            // A full ring evicts its oldest entry, result and all.
            if (full) begin
               oldest_in = ring_at(oldest_ff, CW'(1));
               ovf_in    = 1'b1;
               pend_in   = (pend_ff == occ_ff) ? pend_ff : pend_ff + 1'b1;
            end else begin
               occ_in  = occ_ff + 1'b1;
               pend_in = pend_ff + 1'b1;
            end
            if (half_ff == '0) begin
               mode_in  = M_PASS;
               state_in = S_PASS;
            end else if (item_ff.eor) begin
               mode_in  = M_FLUSH;
               state_in = S_FL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FL: begin
            if (pend_ff == '0) begin
               occ_in    = '0;
               pend_in   = '0;
               oldest_in = '0;
               rsum_in   = '0;
               rcnt_in   = '0;
               ovf_in    = 1'b0;
               state_in  = S_DONE;
            end else begin
               ram_re   = 1'b1;
               state_in = S_FL_TGT;
            end
         end
         S_FL_TGT: begin
            tgt_in   = rd_w;
            state_in = S_L_RD;
         end
         S_PASS: begin
            if (pend_ff == '0) begin
               oldest_in = ring_at(oldest_ff, occ_ff);
               occ_in    = '0;
               if (item_ff.eor) begin
                  oldest_in = '0;
                  rsum_in   = '0;
                  rcnt_in   = '0;
                  ovf_in    = 1'b0;
               end
               state_in = S_DONE;
            end else begin
               ram_re   = 1'b1;
               state_in = S_PASS_EV;
            end
         end
         S_PASS_EV: begin
            rec_in.sample_time_ms  = rd_w.time_ms;
            rec_in.smoothed_q4     = rd_w.valid ? rd_w.power_q4 : '0;
            rec_in.has_value       = rd_w.valid;
            rec_in.window_overflow = ovf_ff;
            rec_in.last_of_run     = 1'b0;
            pend_in  = pend_ff - 1'b1;
            state_in = S_EMIT;
         end
         S_DONE: begin
            if (!stage_v_ff) begin
               state_in = S_IDLE;
            end else if (can_push) begin
               rsp_in             = stage_ff;
               rsp_in.last_of_run = 1'b1;
               rsp_valid_in       = 1'b1;
               stage_v_in         = 1'b0;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_STEP;
         occ_ff       <= '0;
         pend_ff      <= '0;
         oldest_ff    <= '0;
         rsum_ff      <= '0;
         rcnt_ff      <= '0;
         ovf_ff       <= 1'b0;
         half_ff      <= HALF_RESET;
         stage_v_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         occ_ff       <= occ_in;
         pend_ff      <= pend_in;
         oldest_ff    <= oldest_in;
         rsum_ff      <= rsum_in;
         rcnt_ff      <= rcnt_in;
         ovf_ff       <= ovf_in;
         half_ff      <= half_in;
         stage_v_ff   <= stage_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff    <= stage_in;
      rec_ff      <= rec_in;
      rsp_ff      <= rsp_in;
      item_ff     <= item_in;
      tgt_ff      <= tgt_in;
      base_sum_ff <= base_sum_in;
      base_cnt_ff <= base_cnt_in;
      r_ff        <= r_in;
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CTWA_ASSERT(a_occ_bound, clock, reset, occ_ff <= CW'(DEPTH))
   `CTWA_ASSERT(a_pend_in_ring, clock, reset, pend_ff <= occ_ff)
   `CTWA_ASSERT(a_div_nonzero, clock, reset, div_start |-> (cnt_ff != '0))
   `CTWA_NEVER(a_pop_busy, clock, reset, q_pop && (state_ff != S_IDLE))

endmodule

// ----- sim/ctwa_checker.sv -----
module ctwa_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  ctwa_pkg::in_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  ctwa_pkg::out_type             rsp_data,
   input  logic                          csr_wen,
   input  logic [ctwa_pkg::WINDOW_W-1:0] csr_wdata,
   output int                            fail_count,
   output int                            open_count,
   output int                            checked_count
);
   import ctwa_pkg::*;

   localparam int RING = 64;

   bit [31:0] time_ring [RING];
   bit [15:0] power_ring [RING];
   bit        valid_ring [RING];
   bit [23:0] sum_before [RING];
   bit [6:0]  cnt_before [RING];
   bit [23:0] total_sum;
   bit [6:0]  total_cnt;
   int        wr_pos, head, fill, waiting;
   bit        lost_mark;
   bit [11:0] window_s;

   out_type smoothed_q [$];
   out_type beat_q [$];

   assign open_count = smoothed_q.size();

   function automatic int slot(int off);
      return (head + off) % RING;
   endfunction

   function automatic void clear_ride();
      total_sum = 0;
      total_cnt = 0;
      wr_pos    = 0;
      head      = 0;
      fill      = 0;
      waiting   = 0;
      lost_mark = 0;
   endfunction

   function automatic void push_beat(bit [31:0] t, bit [15:0] sm, bit hv);
      out_type o;
      o.sample_time_ms  = t;
      o.smoothed_q4     = sm;
      o.has_value       = hv;
      o.window_overflow = lost_mark;
      o.last_of_run     = 1'b0;
      beat_q.push_back(o);
   endfunction

   // Close the oldest pending sample: trim the left edge, scan the right edge, average.
   function automatic void close_window();
      int f, idx, r, nxt;
      longint unsigned t, half;
      bit [23:0] end_sum, sum;
      bit [6:0]  end_cnt, cnt;
      bit [15:0] sm;
      bit        hv;
      half = longint'(window_s) * 500;
      f    = fill - waiting;
      idx  = slot(f);
      t    = time_ring[idx];
      while (f > 0 && longint'(time_ring[head]) + half < t) begin
         head = (head + 1) % RING;
         fill--;
         f--;
      end
      r = f;
      while (r + 1 < fill && longint'(time_ring[slot(r + 1)]) <= t + half) r++;
      if (r + 1 < fill) begin
         nxt     = slot(r + 1);
         end_sum = sum_before[nxt];
         end_cnt = cnt_before[nxt];
      end else begin
         end_sum = total_sum;
         end_cnt = total_cnt;
      end
      sum = end_sum - sum_before[head];
      cnt = end_cnt - cnt_before[head];
      sm  = 0;
      hv  = 0;
      if (valid_ring[idx] && cnt != 0) begin
         sm = 16'(sum / cnt);
         hv = 1;
      end
      waiting--;
      push_beat(t[31:0], sm, hv);
   endfunction

   function automatic void predict_sample(in_type it);
      bit valid;
      int idx;
      longint unsigned half;
      valid = it.has_power && it.power_q4 != 0;
      half  = longint'(window_s) * 500;
      beat_q.delete();
      if (window_s != 0) begin
         while (waiting > 0) begin
            idx = slot(fill - waiting);
            if (!(longint'(time_ring[idx]) + half < longint'(it.time_ms))) break;
            close_window();
         end
      end
      // evict the oldest entry when the ring is full; a pending one loses its result
      if (fill >= RING) begin
         if (waiting >= fill) waiting--;
         head = (head + 1) % RING;
         fill--;
         lost_mark = 1;
      end
      time_ring[wr_pos]  = it.time_ms;
      power_ring[wr_pos] = it.power_q4;
      valid_ring[wr_pos] = valid;
      sum_before[wr_pos] = total_sum;
      cnt_before[wr_pos] = total_cnt;
      if (valid) begin
         total_sum += it.power_q4;
         total_cnt += 1;
      end
      wr_pos = (wr_pos + 1) % RING;
      fill++;
      waiting++;
      if (window_s == 0) begin
         while (waiting > 0) begin
            idx = slot(fill - waiting);
            waiting--;
            push_beat(time_ring[idx], valid_ring[idx] ? power_ring[idx] : 16'd0,
                      valid_ring[idx]);
         end
         head = wr_pos;
         fill = 0;
      end else if (it.end_of_ride) begin
         while (waiting > 0) close_window();
      end
      if (it.end_of_ride) clear_ride();
      if (beat_q.size() > 0) beat_q[beat_q.size() - 1].last_of_run = 1'b1;
      foreach (beat_q[i]) smoothed_q.push_back(beat_q[i]);
   endfunction

   always @(posedge clock) begin
      out_type want;
      if (reset) begin
         clear_ride();
         window_s = 12'd30;
         smoothed_q.delete();
         fail_count    <= 0;
         checked_count <= 0;
      end else begin
         // compare results first: a beat leaving now never belongs to the item entering now
         if (rsp_valid && rsp_ready) begin
            checked_count <= checked_count + 1;
            if (smoothed_q.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = smoothed_q.pop_front();
               if (rsp_data.sample_time_ms  !== want.sample_time_ms ||
                   rsp_data.smoothed_q4     !== want.smoothed_q4 ||
                   rsp_data.has_value       !== want.has_value ||
                   rsp_data.window_overflow !== want.window_overflow ||
                   rsp_data.last_of_run     !== want.last_of_run) begin
                  $display("%0t: mismatch: expected %p, actual %p", $time, want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) predict_sample(req_data);
         if (csr_wen) window_s = csr_wdata;
      end
   end

endmodule

// ----- sim/tb_centered_time_window_average_unit.sv -----
module tb_centered_time_window_average_unit;
   import ctwa_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   in_type              req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   out_type             rsp_data;
   logic                csr_wen = 1'b0;
   logic [WINDOW_W-1:0] csr_wdata = '0;

   int  fail_count, open_count, checked_count;
   int  cycle_count = 0;
   int  item_count = 0;
   int  ride_count = 0;
   bit  hold_results = 0;   // ask the result side for one long stall
   bit  ready_bursty = 1;
   bit  send_bursty = 1;
   bit [31:0] ride_time;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   centered_time_window_average_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata)
   );

   ctwa_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .open_count    (open_count),
      .checked_count (checked_count)
   );

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_centered_time_window_average_unit failed");
         $finish;
      end
   end

   // Result side: draw a stall per beat, sometimes none, once a long hold-off.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (hold_results) begin
            gap = 400;
            hold_results = 0;
         end else if (ready_bursty) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 17);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if ($urandom_range(0, 40) == 0) ready_bursty = !ready_bursty;
      end
   end

   // Offer one sample beat; hold it until the block takes it.
   task automatic send_sample(bit [31:0] t, bit [15:0] p, bit has, bit eor);
      int gap;
      in_type it;
      gap = send_bursty ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      it.time_ms     = t;
      it.power_q4    = p;
      it.has_power   = has;
      it.end_of_ride = eor;
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      item_count++;
      if ($urandom_range(0, 30) == 0) send_bursty = !send_bursty;
   endtask

   // Drop valid, then wait for every pending result and let the engine settle.
   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_window(bit [11:0] w);
      csr_wen   <= 1'b1;
      csr_wdata <= w;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   // One ride of random content closed by end of ride. Dense rides can overflow the ring.
   task automatic run_ride(int len, int max_step);
      bit [15:0] p;
      bit        has;
      int        k;
      ride_time = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100000);
      for (int i = 0; i < len; i++) begin
         k = $urandom_range(0, 99);
         if (k < 3) ride_time = ride_time - $urandom_range(1, 3000);  // step back in time
         else if (k < 10) ride_time = ride_time;                      // same timestamp
         else ride_time = ride_time + $urandom_range(0, max_step);
         k   = $urandom_range(0, 9);
         has = (k != 0);
         p   = (k == 1) ? 16'd0 : (k == 2) ? 16'hFFFF : (k < 5) ? 16'($urandom) :
               16'($urandom_range(100, 8000));
         send_sample(ride_time, p, has, i == len - 1);
      end
      ride_count++;
   endtask

   initial begin
      bit [11:0] settings [7];
      int w;
      settings = '{12'd30, 12'd1, 12'd3600, 12'd0, 12'd4095, 12'd2, 12'd600};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed ride at the reset window: power extremes, invalid readings,
      // equal and decreasing times, top of the time range, end of ride.
      send_sample(32'd0,        16'd0,     1'b1, 1'b0);
      send_sample(32'd0,        16'hFFFF,  1'b1, 1'b0);
      send_sample(32'd1000,     16'd1,     1'b1, 1'b0);
      send_sample(32'd2000,     16'h1234,  1'b0, 1'b0);
      send_sample(32'd1500,     16'hFFFF,  1'b1, 1'b0);
      send_sample(32'd20000,    16'd800,   1'b1, 1'b0);
      send_sample(32'd60000,    16'hFFFF,  1'b1, 1'b0);
      send_sample(32'hFFFF_0000, 16'd5,    1'b1, 1'b0);
      send_sample(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0);
      send_sample(32'hFFFF_FFFF, 16'd0,    1'b0, 1'b1);
      drain_all();
      // Passthrough: every sample comes straight back.
      write_window(12'd0);
      send_sample(32'd5, 16'd77, 1'b1, 1'b0);
      send_sample(32'd5, 16'd0,  1'b1, 1'b0);
      send_sample(32'd4, 16'd9,  1'b0, 1'b1);
      drain_all();
      // Overflow: 70 samples inside one window, then flush.
      write_window(12'd3600);
      for (int i = 0; i < 70; i++)
         send_sample(32'(i * 10), 16'(i + 1), 1'b1, i == 69);
      drain_all();

      // Random rides; switch the window between rides, only while idle.
      while (item_count < 470) begin
         if (ride_count % 3 == 0) begin
            w = $urandom_range(0, 9);
            write_window(w < 7 ? settings[w] : 12'($urandom_range(0, 3600)));
         end
         if (ride_count == 4) begin
            // stall the result side while a passthrough ride keeps coming in
            write_window(12'd0);
            hold_results = 1;
            run_ride(40, 1500);
         end else if ($urandom_range(0, 3) == 0) begin
            run_ride($urandom_range(30, 90), 60);
         end else begin
            run_ride($urandom_range(3, 30), 2500);
         end
         drain_all();
      end

      $display("%0d samples in %0d rides sent, %0d results checked", item_count,
               ride_count, checked_count);
      $display("windows from passthrough to the 12-bit maximum, with ring overflow");
      if (fail_count == 0 && open_count == 0) begin
         $display("tb_centered_time_window_average_unit passed");
      end else begin
         $display("tb_centered_time_window_average_unit failed");
      end
      $finish;
   end

endmodule
